// File: src/nmea_sentence_framer_checker_assert.svh
// Assertion macros shared by the sentence framer RTL.
// Every macro samples on the rising edge of clock and is disabled while reset is high.
`ifndef NMEA_SENTENCE_FRAMER_CHECKER_ASSERT_SVH
`define NMEA_SENTENCE_FRAMER_CHECKER_ASSERT_SVH

// The consequent holds in the same cycle as the antecedent.
`define NSFC_ASSERT_NOW(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define NSFC_ASSERT_NEXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: src/nsfc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// NMEA sentence framer package
// Character codes, kind codes and the small helper functions of the framer.
// ----------------------------------------------------------------------------
package nsfc_pkg;

   localparam logic [7:0] CH_DOLLAR = 8'h24;
   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_CR     = 8'h0D;

   localparam logic [7:0] LIMIT_RESET = 8'd90;
   localparam logic [7:0] LIMIT_CAP   = 8'd250;
   localparam logic [7:0] COUNT_MAX   = 8'd251;

   localparam int unsigned ADDR_WIDTH = 3;
   localparam logic        REG_MAX_LINE_LENGTH = 1'b0;

   typedef logic [2:0] kind_type;

   localparam kind_type KIND_GGA     = 3'd0;
   localparam kind_type KIND_RMC     = 3'd1;
   localparam kind_type KIND_GSV     = 3'd2;
   localparam kind_type KIND_GLL     = 3'd3;
   localparam kind_type KIND_GSA     = 3'd4;
   localparam kind_type KIND_VTG     = 3'd5;
   localparam kind_type KIND_UNKNOWN = 3'd6;

   function automatic logic [7:0] hex_digit(input logic [3:0] v);
      if (v < 4'd10) begin
         hex_digit = 8'h30 + {4'd0, v};
      end else begin
         hex_digit = 8'h37 + {4'd0, v};
      end
   endfunction

   function automatic kind_type kind_lookup(input logic [7:0] c0, input logic [7:0] c1,
                                            input logic [7:0] c2);
      logic [23:0] s;
      s = {c0, c1, c2};
      case (s)
         "GGA":   kind_lookup = KIND_GGA;
         "RMC":   kind_lookup = KIND_RMC;
         "GSV":   kind_lookup = KIND_GSV;
         "GLL":   kind_lookup = KIND_GLL;
         "GSA":   kind_lookup = KIND_GSA;
         "VTG":   kind_lookup = KIND_VTG;
         default: kind_lookup = KIND_UNKNOWN;
      endcase
   endfunction

endpackage

// File: src/nmea_sentence_framer_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// NMEA sentence framer and checksum checker
// Frames received characters into sentences and checks their star checksum.
// ----------------------------------------------------------------------------
// The req channel carries one received character per item. A dollar sign
// opens a sentence, carriage returns are skipped and a line feed closes it.
// Each closed sentence yields one item on the rsp channel with the checksum
// verdict, the sentence kind, the stored length and the computed XOR.
// Sentences that run past max_line_length (held to at most 250), or that are
// cut short by a new dollar sign, are dropped without a result.
// One character is accepted every cycle while req_stall is low. A line feed's
// result is shown in the next cycle, from a single output register.
// While that register holds an item and the receiver stalls, req_stall is
// high; once the item is taken a new character is accepted in the same cycle.
// The limit register is written through the csr port at byte address 0.
// Reset closes any open sentence, empties the output register and sets the
// limit to 90.
// ----------------------------------------------------------------------------
module nmea_sentence_framer_checker (
   input  logic                             clock,
   input  logic                             reset,

   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [7:0]                       req_rx_byte,

   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic                             rsp_checksum_ok,
   output logic [2:0]                       rsp_sentence_kind,
   output logic [7:0]                       rsp_line_length,
   output logic [7:0]                       rsp_computed_checksum,

   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [nsfc_pkg::ADDR_WIDTH-1:0]  csr_paddr,
   input  logic [31:0]                      csr_pwdata,
   output logic [31:0]                      csr_prdata,
   output logic                             csr_pready
);

`include "nmea_sentence_framer_checker_assert.svh"

   logic [7:0]         max_len_ff, max_len_in;
   logic [7:0]         count_ff, count_in;
   logic [7:0]         xor_ff, xor_in;
   logic [7:0]         recent_ff [3];
   logic [7:0]         recent_in [3];
   logic [7:0]         talker_ff [3];
   logic [7:0]         talker_in [3];

   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_ok_ff, rsp_ok_in;
   nsfc_pkg::kind_type rsp_kind_ff, rsp_kind_in;
   logic [7:0]         rsp_len_ff, rsp_len_in;
   logic [7:0]         rsp_xor_ff, rsp_xor_in;

   logic               accept;
   logic               cfg_write;
   logic               fire;
   logic [7:0]         limit;
   logic [7:0]         len;
   logic               ok;
   nsfc_pkg::kind_type kind;

   assign req_stall  = rsp_valid_ff & rsp_stall;
   assign accept     = req_valid & ~req_stall;
   assign csr_pready = 1'b1;
   assign cfg_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;

   assign csr_prdata = (csr_paddr[2] == nsfc_pkg::REG_MAX_LINE_LENGTH) ?
                       {24'd0, max_len_ff} : 32'd0;

   assign max_len_in = (cfg_write && csr_paddr[2] == nsfc_pkg::REG_MAX_LINE_LENGTH) ?
                       csr_pwdata[7:0] : max_len_ff;

   assign limit = (max_len_ff > nsfc_pkg::LIMIT_CAP) ? nsfc_pkg::LIMIT_CAP : max_len_ff;
   assign len   = count_ff + 8'd1;

   assign ok = (count_ff >= 8'd4)
            && (recent_ff[0] == nsfc_pkg::CH_STAR)
            && (recent_ff[1] == nsfc_pkg::hex_digit(xor_ff[7:4]))
            && (recent_ff[2] == nsfc_pkg::hex_digit(xor_ff[3:0]));

   // A line feed at positions three to five lands in the kind field and matches nothing.
   assign kind = (ok && count_ff > 8'd5) ?
                 nsfc_pkg::kind_lookup(talker_ff[0], talker_ff[1], talker_ff[2]) :
                 nsfc_pkg::KIND_UNKNOWN;

   always_comb begin
      count_in  = count_ff;
      xor_in    = xor_ff;
      recent_in = recent_ff;
      talker_in = talker_ff;
      fire      = 1'b0;
      if (accept) begin
         if (req_rx_byte == nsfc_pkg::CH_DOLLAR) begin
            count_in  = 8'd1;
            xor_in    = 8'd0;
            recent_in = '{default: 8'd0};
            talker_in = '{default: 8'd0};
         end else if (count_ff > limit) begin
            count_in = 8'd0;
         end else if (count_ff == 8'd0 || req_rx_byte == nsfc_pkg::CH_CR) begin
            count_in = count_ff;
         end else if (req_rx_byte == nsfc_pkg::CH_LF) begin
            fire     = 1'b1;
            count_in = 8'd0;
         end else begin
            if (count_ff >= 8'd4) begin
               xor_in = xor_ff ^ recent_ff[0];
            end
            recent_in[0] = recent_ff[1];
            recent_in[1] = recent_ff[2];
            recent_in[2] = req_rx_byte;
            if (count_ff == 8'd3) begin
               talker_in[0] = req_rx_byte;
            end
            if (count_ff == 8'd4) begin
               talker_in[1] = req_rx_byte;
            end
            if (count_ff == 8'd5) begin
               talker_in[2] = req_rx_byte;
            end
            count_in = len;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_ok_in    = rsp_ok_ff;
      rsp_kind_in  = rsp_kind_ff;
      rsp_len_in   = rsp_len_ff;
      rsp_xor_in   = rsp_xor_ff;
      if (!rsp_valid_ff || !rsp_stall) begin
         rsp_valid_in = fire;
      end
      if (fire) begin
         rsp_ok_in   = ok;
         rsp_kind_in = kind;
         rsp_len_in  = len;
         rsp_xor_in  = xor_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff   <= nsfc_pkg::LIMIT_RESET;
         count_ff     <= 8'd0;
         xor_ff       <= 8'd0;
         recent_ff    <= '{default: 8'd0};
         talker_ff    <= '{default: 8'd0};
         rsp_valid_ff <= 1'b0;
      end else begin
         max_len_ff   <= max_len_in;
         count_ff     <= count_in;
         xor_ff       <= xor_in;
         recent_ff    <= recent_in;
         talker_ff    <= talker_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ok_ff   <= rsp_ok_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_len_ff  <= rsp_len_in;
      rsp_xor_ff  <= rsp_xor_in;
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_checksum_ok       = rsp_ok_ff;
   assign rsp_sentence_kind     = rsp_kind_ff;
   assign rsp_line_length       = rsp_len_ff;
   assign rsp_computed_checksum = rsp_xor_ff;

   `NSFC_ASSERT_NOW(a_count_cap, 1'b1, count_ff <= nsfc_pkg::COUNT_MAX,
      "sentence length ran past its cap")
   `NSFC_ASSERT_NOW(a_kind_needs_ok, rsp_valid_ff && rsp_kind_ff != nsfc_pkg::KIND_UNKNOWN,
      rsp_ok_ff, "known sentence kind reported with a bad checksum")
   `NSFC_ASSERT_NOW(a_ok_needs_length, rsp_valid_ff && rsp_ok_ff, rsp_len_ff >= 8'd5,
      "checksum accepted on a short sentence")
   `NSFC_ASSERT_NEXT(a_dollar_opens, accept && req_rx_byte == nsfc_pkg::CH_DOLLAR,
      count_ff == 8'd1 && xor_ff == 8'd0, "dollar sign did not open a fresh sentence")

endmodule
